// File: hw/rtl/dira_pkg.sv
// dira_pkg: shared types and constants for the dual input ring arbiter.
// No dependencies; imported by the controller, datapath and top level.
package dira_pkg;

  localparam int DATA_W = 64;
  localparam int CNT_W  = 32;
  localparam int PEND_W = 4;
  localparam int LEN_W  = 8;
  localparam int MODE_W = 2;

  localparam int DefRingDepth    = 16;
  localparam int DefMessageBytes = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUB_PTR = 2'd0,
    MODE_PUB_KEY = 2'd1,
    MODE_READ    = 2'd2,
    MODE_STATS   = 2'd3
  } mode_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic exec;     // perform the operation on the rings
    logic present;  // result is on the ports this cycle
  } ctrl_cmd_t;

endpackage

// File: hw/rtl/dira_ctrl.sv
// dira_ctrl: sequencing state machine for the dual input ring arbiter.
// Depends on dira_pkg; drives the datapath through a ctrl_cmd_t.
module dira_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output dira_pkg::ctrl_cmd_t cmd_o
);
  import dira_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   accept;

  assign busy_o = (state_q == ST_EXEC);
  assign accept = start_i && !busy_o;

  assign cmd_o.load    = accept;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.present = (state_q == ST_RESP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          state_q <= accept ? ST_EXEC : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dira_dpath.sv
// dira_dpath: ring storage, head/tail pointers, drop counters and result regs.
// Depends on dira_pkg; commanded by dira_ctrl.
module dira_dpath #(
  parameter int RING_DEPTH    = dira_pkg::DefRingDepth,
  parameter int MESSAGE_BYTES = dira_pkg::DefMessageBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dira_pkg::ctrl_cmd_t         cmd_i,
  input  logic [dira_pkg::MODE_W-1:0] mode_i,
  input  logic [dira_pkg::DATA_W-1:0] payload_i,
  input  logic [dira_pkg::LEN_W-1:0]  read_length_i,
  output logic                        res_valid_o,
  output logic                        done_res_o,
  output logic                        read_source_o,
  output logic [dira_pkg::DATA_W-1:0] read_data_o,
  output logic [dira_pkg::CNT_W-1:0]  pointer_dropped_o,
  output logic [dira_pkg::CNT_W-1:0]  key_dropped_o,
  output logic [dira_pkg::PEND_W-1:0] pointer_pending_o,
  output logic [dira_pkg::PEND_W-1:0] key_pending_o
);
  import dira_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = (AW + 1 > PEND_W) ? AW + 1 : PEND_W;
  localparam logic [AW-1:0]     LastIdx  = AW'(RING_DEPTH - 1);
  localparam logic [PW-1:0]     DepthP   = PW'(RING_DEPTH);
  localparam logic [LEN_W-1:0]  MsgBytes = LEN_W'(MESSAGE_BYTES);
  localparam logic [DATA_W-1:0] WordMask = {DATA_W{1'b1}} >> (DATA_W - 8 * MESSAGE_BYTES);

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    next_idx = (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [PEND_W-1:0] pending(input logic [AW-1:0] head,
                                                input logic [AW-1:0] tail);
    logic [PW-1:0] diff;
    if (tail >= head) diff = PW'(tail) - PW'(head);
    else              diff = PW'(tail) + DepthP - PW'(head);
    pending = diff[PEND_W-1:0];
  endfunction

  // Captured item
  logic [MODE_W-1:0] mode_q;
  logic [DATA_W-1:0] payload_q;
  logic [LEN_W-1:0]  len_q;

  // Ring control state
  logic [AW-1:0]    p_head_q, p_tail_q, k_head_q, k_tail_q;
  logic [CNT_W-1:0] p_drop_q, k_drop_q;
  logic             prefer_ptr_q;

  // Storage and read registers
  logic [DATA_W-1:0] p_mem [RING_DEPTH];
  logic [DATA_W-1:0] k_mem [RING_DEPTH];
  logic [DATA_W-1:0] p_rd_q, k_rd_q;

  // Result registers
  logic              done_q, src_q, deliver_q;
  logic [CNT_W-1:0]  pd_q, kd_q;
  logic [PEND_W-1:0] pp_q, kp_q;

  logic [AW-1:0] p_tnext, k_tnext;
  logic p_full, k_full, p_rdy, k_rdy, room_ok, take_key;
  logic p_wr, k_wr, p_rd, k_rd, p_drop, k_drop, do_read, do_stats;

  always_comb begin
    p_tnext  = next_idx(p_tail_q);
    k_tnext  = next_idx(k_tail_q);
    p_full   = (p_tnext == p_head_q);
    k_full   = (k_tnext == k_head_q);
    p_rdy    = (p_head_q != p_tail_q);
    k_rdy    = (k_head_q != k_tail_q);
    room_ok  = (len_q >= MsgBytes);
    take_key = k_rdy && (!p_rdy || !prefer_ptr_q);
    p_wr = 1'b0; k_wr = 1'b0; p_drop = 1'b0; k_drop = 1'b0;
    do_read = 1'b0; do_stats = 1'b0;
    if (cmd_i.exec) begin
      unique case (mode_e'(mode_q))
        MODE_PUB_PTR: begin
          p_wr = !p_full; p_drop = p_full;
        end
        MODE_PUB_KEY: begin
          k_wr = !k_full; k_drop = k_full;
        end
        MODE_READ: begin
          do_read = room_ok && (k_rdy || p_rdy);
        end
        MODE_STATS: begin
          do_stats = 1'b1;
        end
        default: ;
      endcase
    end
    k_rd = do_read && take_key;
    p_rd = do_read && !take_key;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      payload_q <= payload_i;
      len_q     <= read_length_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_wr) p_mem[p_tail_q] <= payload_q & WordMask;
    if (p_rd) p_rd_q <= p_mem[p_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (k_wr) k_mem[k_tail_q] <= payload_q & WordMask;
    if (k_rd) k_rd_q <= k_mem[k_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q     <= '0;
      p_tail_q     <= '0;
      k_head_q     <= '0;
      k_tail_q     <= '0;
      p_drop_q     <= '0;
      k_drop_q     <= '0;
      prefer_ptr_q <= 1'b0;
      done_q       <= 1'b0;
      src_q        <= 1'b0;
      deliver_q    <= 1'b0;
      pd_q         <= '0;
      kd_q         <= '0;
      pp_q         <= '0;
      kp_q         <= '0;
    end else begin
      if (p_wr)   p_tail_q <= p_tnext;
      if (k_wr)   k_tail_q <= k_tnext;
      if (p_drop) p_drop_q <= p_drop_q + CNT_W'(1);
      if (k_drop) k_drop_q <= k_drop_q + CNT_W'(1);
      if (k_rd) begin
        k_head_q     <= next_idx(k_head_q);
        prefer_ptr_q <= 1'b1;
      end
      if (p_rd) begin
        p_head_q     <= next_idx(p_head_q);
        prefer_ptr_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        done_q    <= p_wr || k_wr || do_read || do_stats;
        src_q     <= p_rd;
        deliver_q <= do_read;
        pd_q      <= do_stats ? p_drop_q : '0;
        kd_q      <= do_stats ? k_drop_q : '0;
        pp_q      <= do_stats ? pending(p_head_q, p_tail_q) : '0;
        kp_q      <= do_stats ? pending(k_head_q, k_tail_q) : '0;
      end
    end
  end

  assign res_valid_o       = cmd_i.present;
  assign done_res_o        = done_q;
  assign read_source_o     = src_q;
  assign read_data_o       = !deliver_q ? '0 : (src_q ? p_rd_q : k_rd_q);
  assign pointer_dropped_o = pd_q;
  assign key_dropped_o     = kd_q;
  assign pointer_pending_o = pp_q;
  assign key_pending_o     = kp_q;

endmodule

// File: hw/rtl/dual_input_ring_arbiter.sv
// dual_input_ring_arbiter: top level, controller plus ring datapath.
// Depends on dira_pkg, dira_ctrl and dira_dpath.

// Two circular queues (pointer events, key events), each keeping one slot
// empty, merged by a single reader that alternates between them when both
// hold data. An item is taken when start_i is high and busy_o is low; mode_i
// selects publish pointer, publish key, read one message, or stats. Every
// item produces exactly one result, shown for one cycle with res_valid_o
// high; the receiver cannot hold it off, so it must sample on that cycle.
// Sequence: an item is executed in the execution state (pointer compare plus one
// ring memory access with registered read data) and its result appears in
// the next cycle. busy_o is high only during the execution state, so a new
// item may be started in the same cycle a result is shown; the block does
// not take a new item while one is executing. Ring contents are not cleared
// by reset; only entries between head and tail are ever read.
module dual_input_ring_arbiter #(
  parameter int RING_DEPTH    = dira_pkg::DefRingDepth,
  parameter int MESSAGE_BYTES = dira_pkg::DefMessageBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dira_pkg::MODE_W-1:0] mode_i,
  input  logic [dira_pkg::DATA_W-1:0] payload_i,
  input  logic [dira_pkg::LEN_W-1:0]  read_length_i,
  output logic                        res_valid_o,
  output logic                        done_res_o,
  output logic                        read_source_o,
  output logic [dira_pkg::DATA_W-1:0] read_data_o,
  output logic [dira_pkg::CNT_W-1:0]  pointer_dropped_o,
  output logic [dira_pkg::CNT_W-1:0]  key_dropped_o,
  output logic [dira_pkg::PEND_W-1:0] pointer_pending_o,
  output logic [dira_pkg::PEND_W-1:0] key_pending_o
);
  import dira_pkg::*;

  ctrl_cmd_t cmd;

  // Sequencer: idle -> execute -> present result
  dira_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Rings, pointers, drop counters and result registers
  dira_dpath #(
    .RING_DEPTH    (RING_DEPTH),
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mode_i            (mode_i),
    .payload_i         (payload_i),
    .read_length_i     (read_length_i),
    .res_valid_o       (res_valid_o),
    .done_res_o        (done_res_o),
    .read_source_o     (read_source_o),
    .read_data_o       (read_data_o),
    .pointer_dropped_o (pointer_dropped_o),
    .key_dropped_o     (key_dropped_o),
    .pointer_pending_o (pointer_pending_o),
    .key_pending_o     (key_pending_o)
  );

endmodule

// File: tb/dual_input_ring_arbiter_test.sv
// dual_input_ring_arbiter_test: self-checking bench for the dual ring arbiter.
// Depends on dira_pkg and dual_input_ring_arbiter; a queue-fed driver, a
// result monitor and a cycle-free predictor of both rings.
module dual_input_ring_arbiter_test;
  import dira_pkg::*;

  localparam int RING_SLOTS = DefRingDepth;
  localparam int MSG_BYTES  = DefMessageBytes;
  // Only the low MSG_BYTES bytes of a published word are kept in the ring.
  localparam logic [DATA_W-1:0] WORD_MASK =
    (MSG_BYTES >= 8) ? {DATA_W{1'b1}} : ((64'd1 << (8 * MSG_BYTES)) - 64'd1);

  // One command item as the driver presents it.
  typedef struct {
    mode_e              mode;
    logic [DATA_W-1:0]  payload;
    logic [LEN_W-1:0]   room;
  } ring_cmd_t;

  // One result item, field for field as the block reports it.
  typedef struct {
    logic               done;
    logic               src;
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   ptr_drops;
    logic [CNT_W-1:0]   key_drops;
    logic [PEND_W-1:0]  ptr_pend;
    logic [PEND_W-1:0]  key_pend;
  } ring_result_t;

  // Clock, reset and every block input start at known values.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  mode_e             mode_i        = MODE_PUB_PTR;
  logic [DATA_W-1:0] payload_i     = '0;
  logic [LEN_W-1:0]  read_length_i = '0;
  logic              busy_o;
  logic              res_valid_o;
  logic              done_res_o;
  logic              read_source_o;
  logic [DATA_W-1:0] read_data_o;
  logic [CNT_W-1:0]  pointer_dropped_o;
  logic [CNT_W-1:0]  key_dropped_o;
  logic [PEND_W-1:0] pointer_pending_o;
  logic [PEND_W-1:0] key_pending_o;

  dual_input_ring_arbiter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mode_i            (mode_i),
    .payload_i         (payload_i),
    .read_length_i     (read_length_i),
    .res_valid_o       (res_valid_o),
    .done_res_o        (done_res_o),
    .read_source_o     (read_source_o),
    .read_data_o       (read_data_o),
    .pointer_dropped_o (pointer_dropped_o),
    .key_dropped_o     (key_dropped_o),
    .pointer_pending_o (pointer_pending_o),
    .key_pending_o     (key_pending_o)
  );

  always #10 clk_i = ~clk_i;

  // Items waiting to be presented, and results owed by the block, oldest first.
  ring_cmd_t    cmd_q[$];
  ring_result_t owed_results_q[$];
  int           send_idle_pct = 38;
  int           mismatches    = 0;

  // Shadow copy of the two rings. Heads and tails are kept mod RING_SLOTS.
  logic [DATA_W-1:0] ptr_ring[RING_SLOTS];
  logic [DATA_W-1:0] key_ring[RING_SLOTS];
  int                ptr_head = 0, ptr_tail = 0, key_head = 0, key_tail = 0;
  logic [CNT_W-1:0]  ptr_drop_cnt = '0, key_drop_cnt = '0;
  logic              prefer_ptr = 1'b0;

  // Apply one accepted item to the shadow rings; return the result it owes.
  function automatic ring_result_t arbitrate_item(ring_cmd_t c);
    ring_result_t r;
    bit           key_ready;
    bit           ptr_ready;
    r = '{done: 1'b0, src: 1'b0, data: '0, ptr_drops: '0, key_drops: '0,
          ptr_pend: '0, key_pend: '0};
    key_ready = (key_head != key_tail);
    ptr_ready = (ptr_head != ptr_tail);
    case (c.mode)
      MODE_PUB_PTR: begin
        // Full ring (one slot always left empty): drop and count.
        if ((ptr_tail + 1) % RING_SLOTS == ptr_head) begin
          ptr_drop_cnt += 1;
        end else begin
          ptr_ring[ptr_tail] = c.payload & WORD_MASK;
          ptr_tail = (ptr_tail + 1) % RING_SLOTS;
          r.done = 1'b1;
        end
      end
      MODE_PUB_KEY: begin
        if ((key_tail + 1) % RING_SLOTS == key_head) begin
          key_drop_cnt += 1;
        end else begin
          key_ring[key_tail] = c.payload & WORD_MASK;
          key_tail = (key_tail + 1) % RING_SLOTS;
          r.done = 1'b1;
        end
      end
      MODE_READ: begin
        // Short room or nothing queued: no delivery, preference untouched.
        if (c.room >= MSG_BYTES && (key_ready || ptr_ready)) begin
          if (key_ready && (!ptr_ready || !prefer_ptr)) begin
            r.data     = key_ring[key_head];
            key_head   = (key_head + 1) % RING_SLOTS;
            r.src      = 1'b0;
            prefer_ptr = 1'b1;
          end else begin
            r.data     = ptr_ring[ptr_head];
            ptr_head   = (ptr_head + 1) % RING_SLOTS;
            r.src      = 1'b1;
            prefer_ptr = 1'b0;
          end
          r.done = 1'b1;
        end
      end
      MODE_STATS: begin
        r.done      = 1'b1;
        r.ptr_drops = ptr_drop_cnt;
        r.key_drops = key_drop_cnt;
        r.ptr_pend  = PEND_W'((ptr_tail + RING_SLOTS - ptr_head) % RING_SLOTS);
        r.key_pend  = PEND_W'((key_tail + RING_SLOTS - key_head) % RING_SLOTS);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver. An item is taken at an edge where start_i is high and busy_o low;
  // the prediction is made right there, from the values on the ports. While
  // busy_o holds the item off, start_i and the fields stay put. Otherwise a
  // new item goes out unless the sender idles this cycle. start_i gets one
  // assignment per edge, so a back-to-back item never toggles it.
  always @(posedge clk_i) begin : drive_proc
    ring_cmd_t nxt;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        owed_results_q.push_back(arbitrate_item('{mode: mode_i, payload: payload_i,
                                                  room: read_length_i}));
      end
      if (!start_i || !busy_o) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt           = cmd_q.pop_front();
          start_i       <= 1'b1;
          mode_i        <= nxt.mode;
          payload_i     <= nxt.payload;
          read_length_i <= nxt.room;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v,
                             logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Monitor. A result is on the ports for exactly one cycle; it is taken at
  // the edge that ends that cycle and matched against the oldest owed result.
  always @(posedge clk_i) begin : monitor_proc
    ring_result_t want;
    if (rst_ni && res_valid_o) begin
      if (owed_results_q.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatches++;
      end else begin
        want = owed_results_q.pop_front();
        check_field("done_res",        DATA_W'(want.done),      DATA_W'(done_res_o));
        check_field("read_source",     DATA_W'(want.src),       DATA_W'(read_source_o));
        check_field("read_data",       want.data,               read_data_o);
        check_field("pointer_dropped", DATA_W'(want.ptr_drops), DATA_W'(pointer_dropped_o));
        check_field("key_dropped",     DATA_W'(want.key_drops), DATA_W'(key_dropped_o));
        check_field("pointer_pending", DATA_W'(want.ptr_pend),  DATA_W'(pointer_pending_o));
        check_field("key_pending",     DATA_W'(want.key_pend),  DATA_W'(key_pending_o));
      end
    end
  end

  task automatic push_cmd(mode_e m, logic [DATA_W-1:0] p, logic [LEN_W-1:0] len);
    cmd_q.push_back('{mode: m, payload: p, room: len});
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random traffic in segments: publish bursts long enough to fill a ring
  // and overflow it, read bursts that drain, mixed traffic, and noise with
  // short read room. Stats are sprinkled in to expose counts and occupancy.
  task automatic gen_traffic(int n);
    int made;
    int seg;
    int len;
    mode_e pub;
    made = 0;
    while (made < n) begin
      seg = $urandom_range(9);
      len = $urandom_range(4, 20);
      pub = $urandom_range(1) ? MODE_PUB_PTR : MODE_PUB_KEY;
      for (int i = 0; i < len; i++) begin
        case (seg)
          0, 1, 2: push_cmd(($urandom_range(5) == 0) ? MODE_READ : pub, rand_word(),
                            LEN_W'($urandom_range(8, 255)));
          3, 4, 5: push_cmd(($urandom_range(4) == 0) ? pub : MODE_READ, rand_word(),
                            ($urandom_range(7) == 0) ? LEN_W'($urandom_range(255))
                                                     : LEN_W'($urandom_range(8, 255)));
          6, 7: push_cmd(mode_e'($urandom_range(2)), rand_word(),
                         LEN_W'($urandom_range(6, 255)));
          default: push_cmd(mode_e'($urandom_range(3)), rand_word(),
                            LEN_W'($urandom_range(255)));
        endcase
      end
      made += len;
      if ($urandom_range(3) == 0) begin
        push_cmd(MODE_STATS, rand_word(), LEN_W'($urandom_range(255)));
        made++;
      end
    end
  endtask

  // Sender holds off until the block has returned every owed result.
  task automatic wait_quiet();
    while (cmd_q.size() != 0 || start_i || owed_results_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty reads, extreme payloads, short room, alternation,
    // single-ring drain, stats along the way.
    push_cmd(MODE_STATS,   rand_word(),       8'd0);
    push_cmd(MODE_READ,    '0,                8'd255);   // both rings empty
    push_cmd(MODE_READ,    '1,                8'd0);
    push_cmd(MODE_PUB_PTR, '1,                8'd0);
    push_cmd(MODE_PUB_PTR, '0,                8'd255);
    push_cmd(MODE_PUB_KEY, 64'h5555_5555_5555_5555, 8'd0);
    push_cmd(MODE_PUB_KEY, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0);
    push_cmd(MODE_STATS,   '1,                8'd255);
    push_cmd(MODE_READ,    '0,                8'd7);     // room one byte short
    push_cmd(MODE_READ,    '0,                8'd0);
    push_cmd(MODE_READ,    '0,                8'd8);     // key first after reset
    push_cmd(MODE_READ,    '0,                8'd255);   // then pointer
    push_cmd(MODE_READ,    '0,                8'd8);
    push_cmd(MODE_READ,    '0,                8'd8);
    push_cmd(MODE_READ,    '0,                8'd8);     // empty again
    push_cmd(MODE_PUB_PTR, rand_word(),       8'd0);
    push_cmd(MODE_PUB_PTR, rand_word(),       8'd0);
    push_cmd(MODE_READ,    rand_word(),       8'd200);   // only pointer ring holds data
    push_cmd(MODE_READ,    rand_word(),       8'd9);
    push_cmd(MODE_PUB_KEY, rand_word(),       8'd0);
    push_cmd(MODE_READ,    rand_word(),       8'd128);   // only key ring holds data
    push_cmd(MODE_STATS,   '0,                8'd0);
    gen_traffic(115);
    wait_quiet();

    send_idle_pct = 63;
    gen_traffic(130);
    wait_quiet();

    send_idle_pct = 0;
    gen_traffic(130);
    wait_quiet();

    // Wait further to catch any stray strobe.
    repeat (6) @(negedge clk_i);
    if (mismatches == 0 && owed_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
